>>> rtl/iapp_pkg.sv
// Shared types and constants for the IMU angle packet parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package iapp_pkg;

    // Packet layout
    localparam int unsigned PKT_LEN = 11;
    localparam logic [7:0] HDR0 = 8'h55;
    localparam logic [7:0] HDR1 = 8'h53;

    // Byte positions within a packet
    localparam logic [3:0] POS_HDR0  = 4'd0;
    localparam logic [3:0] POS_HDR1  = 4'd1;
    localparam logic [3:0] POS_ROLL  = 4'd2;
    localparam logic [3:0] POS_YAWHI = 4'd7;
    localparam logic [3:0] POS_CSUM  = 4'(PKT_LEN - 1);

    // Angle bytes held: roll lo/hi, pitch lo/hi, yaw lo/hi
    localparam int unsigned ANGLE_BYTES = 6;

    // Yaw scale: raw * 180 / 256 gives 1/128 degree units
    localparam int unsigned YAW_SCALE = 180;
    localparam int unsigned PROD_W    = 25;

    localparam int unsigned OUT_TDATA_W = 72;

    // One parsed packet
    typedef struct packed {
        logic               packet_ok;
        logic signed [15:0] roll_raw;
        logic signed [15:0] pitch_raw;
        logic signed [15:0] yaw_raw;
        logic signed [15:0] yaw_deg_q7;
    } result_t;

endpackage

>>> rtl/iapp_frame.sv
// Input register, packet framing, header and checksum check, angle decode.
// Depends on iapp_pkg.
`timescale 1ns / 1ps

module iapp_frame (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              advance,
    output logic              res_valid,
    output iapp_pkg::result_t res
);
    import iapp_pkg::*;

    logic                  byte_vld_reg, byte_vld_next;
    logic [7:0]            byte_reg;
    logic [3:0]            count_reg, count_next;
    logic [7:0]            sum_reg, sum_next;
    logic [7:0]            hdr0_reg;
    logic [7:0]            angle_reg [ANGLE_BYTES];
    logic                  accept;
    logic                  fire;
    logic [7:0]            sum_new;
    logic                  store_en;
    logic [2:0]            store_idx;
    logic                  csum_ok;
    logic signed [15:0]    roll;
    logic signed [15:0]    pitch;
    logic signed [15:0]    yaw;
    logic signed [PROD_W-1:0] yaw_prod;

    // Input register takes a new byte when it is empty or the held one moves on
    assign in_ready = !byte_vld_reg || advance;
    assign accept   = in_valid && in_ready;
    assign fire     = byte_vld_reg && advance;

    always_comb
    begin
        if (accept)
        begin
            byte_vld_next = 1'b1;
        end
        else if (advance)
        begin
            byte_vld_next = 1'b0;
        end
        else
        begin
            byte_vld_next = byte_vld_reg;
        end
    end

    // Framing: count, running sum, header check, restart
    assign sum_new   = sum_reg + byte_reg;
    assign store_en  = fire && (count_reg >= POS_ROLL) && (count_reg <= POS_YAWHI);
    assign store_idx = 3'(count_reg - POS_ROLL);

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (fire)
        begin
            unique case (count_reg)
                POS_HDR1:
                begin
                    if (hdr0_reg == HDR0 && byte_reg == HDR1)
                    begin
                        count_next = count_reg + 4'd1;
                        sum_next   = sum_new;
                    end
                    else
                    begin
                        count_next = '0;
                        sum_next   = '0;
                    end
                end
                POS_CSUM:
                begin
                    count_next = '0;
                    sum_next   = '0;
                end
                default:
                begin
                    count_next = count_reg + 4'd1;
                    sum_next   = sum_new;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            byte_vld_reg <= byte_vld_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
        end
        if (fire && count_reg == POS_HDR0)
        begin
            hdr0_reg <= byte_reg;
        end
        if (store_en)
        begin
            angle_reg[store_idx] <= byte_reg;
        end
    end

    // Decode angles; sum of bytes 0..9 must equal byte 10
    assign csum_ok  = (sum_reg == byte_reg);
    assign roll     = {angle_reg[1], angle_reg[0]};
    assign pitch    = {angle_reg[3], angle_reg[2]};
    assign yaw      = {angle_reg[5], angle_reg[4]};
    assign yaw_prod = PROD_W'(yaw) * $signed(PROD_W'(YAW_SCALE));

    assign res_valid = fire && (count_reg == POS_CSUM);

    always_comb
    begin
        res.packet_ok = csum_ok;
        if (csum_ok)
        begin
            res.roll_raw   = roll;
            res.pitch_raw  = pitch;
            res.yaw_raw    = yaw;
            res.yaw_deg_q7 = yaw_prod[23:8];
        end
        else
        begin
            res.roll_raw   = '0;
            res.pitch_raw  = '0;
            res.yaw_raw    = '0;
            res.yaw_deg_q7 = '0;
        end
    end

endmodule

>>> rtl/iapp_out.sv
// Result register driving the output stream channel.
// Depends on iapp_pkg.
`timescale 1ns / 1ps

module iapp_out (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                res_valid,
    input  iapp_pkg::result_t                   res,
    output logic                                advance,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [iapp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import iapp_pkg::*;

    localparam int unsigned RES_W = $bits(result_t);

    logic    out_vld_reg, out_vld_next;
    result_t out_reg;

    // Upstream may move when the result register is free or draining
    assign advance = !out_vld_reg || m_axis_tready;

    always_comb
    begin
        if (advance)
        begin
            out_vld_next = res_valid;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    // Hold payload until the transaction completes
    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    // Pack from the lowest bit: packet_ok, roll, pitch, yaw, yaw_deg_q7, zero fill
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}},
                            out_reg.yaw_deg_q7, out_reg.yaw_raw,
                            out_reg.pitch_raw, out_reg.roll_raw, out_reg.packet_ok};

endmodule

>>> rtl/imu_angle_packet_parser.sv
// Top level of the IMU angle packet parser.
// Depends on iapp_pkg, iapp_frame and iapp_out.
//
// Usage:
//   s_axis carries received UART bytes, one per transaction. Packets are
//   11 bytes: 0x55, 0x53, roll lo/hi, pitch lo/hi, yaw lo/hi, two spare
//   bytes and an 8-bit checksum of the first ten bytes. A pair of bytes
//   that is not the header is dropped and framing restarts.
//   m_axis gives one transaction per completed packet: packet_ok, the raw
//   signed angles and yaw in 1/128 degree. On a checksum failure
//   packet_ok is 0 and the angle fields are 0.
//   Throughput: one byte per cycle while the receiver does not stall.
//   Latency: the checksum byte passes the input register, then the result
//   register, before m_axis_tvalid rises; the yaw scaling multiply sits
//   between them. Reset clears framing state and both valid flags; the
//   parser then waits for a header. When the receiver stalls, the result
//   is held and the input register stops advancing: at most one more byte
//   is taken, then s_axis_tready stays low until the result transaction
//   completes.
`timescale 1ns / 1ps

module imu_angle_packet_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] packet_ok, [16:1] roll_raw, [32:17] pitch_raw, [48:33] yaw_raw,
    // [64:49] yaw_deg_q7, [71:65] zero
    output logic [iapp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import iapp_pkg::*;

    logic    advance;
    logic    res_valid;
    result_t res;

    iapp_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    iapp_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> test/tb.sv
// Testbench for imu_angle_packet_parser: feeds UART byte streams and checks parsed packets.
// Depends on iapp_pkg and the RTL of the parser; reads no files and needs no arguments.
`timescale 1ns / 1ps

module tb;

    import iapp_pkg::*;

    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned STALL_LIMIT   = 3000;
    localparam int unsigned PACKET_TARGET = 1050;
    localparam int unsigned TAIL_CYCLES   = 8;

    // One entry of the byte stream; a pause entry waits for all results
    typedef struct {
        bit         pause;
        logic [7:0] value;
    } stream_entry_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'h00;  // [7:0] rx_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] packet_ok, [16:1] roll_raw, [32:17] pitch_raw, [48:33] yaw_raw,
    // [64:49] yaw_deg_q7, [71:65] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    stream_entry_t byte_stream[$];
    result_t       expected_packets[$];

    // Parser state mirrored by the predictor
    logic [3:0] frame_len;
    logic [7:0] frame_sum;
    logic [7:0] frame_bytes [0:PKT_LEN-1];

    int fail_count      = 0;
    int bytes_in        = 0;
    int packets_seen    = 0;
    int outstanding     = 0;
    int idle_cycles     = 0;
    int good_packets    = 0;
    int bad_sum_packets = 0;
    int dropped_pairs   = 0;
    int stall_left      = 0;
    bit first_hold_done  = 1'b0;
    bit second_hold_done = 1'b0;
    bit calm;

    imu_angle_packet_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // No random idling on either side in this stretch of the run
    assign calm = (bytes_in >= 450) && (bytes_in < 700);

    // Clear the framing state after a packet or a bad header
    task automatic clear_frame();
        frame_len = '0;
        frame_sum = '0;
        for (int i = 0; i < PKT_LEN; i++)
            frame_bytes[i] = '0;
    endtask

    // Advance the framing state by one byte; queue the parsed packet if one completes
    task automatic parse_byte(input logic [7:0] rx, output bit produced);
        result_t    pkt;
        logic [7:0] head_sum;
        int         yaw_prod;
        produced = 1'b0;
        frame_bytes[frame_len] = rx;
        frame_sum = frame_sum + rx;
        frame_len = frame_len + 4'd1;
        if (frame_len == 4'd2 && (frame_bytes[0] != HDR0 || frame_bytes[1] != HDR1)) begin
            dropped_pairs++;
            clear_frame();
        end else if (frame_len == 4'(PKT_LEN)) begin
            pkt = '0;
            head_sum = frame_sum - frame_bytes[PKT_LEN-1];
            pkt.packet_ok = (head_sum == frame_bytes[PKT_LEN-1]);
            if (pkt.packet_ok) begin
                pkt.roll_raw  = {frame_bytes[3], frame_bytes[2]};
                pkt.pitch_raw = {frame_bytes[5], frame_bytes[4]};
                pkt.yaw_raw   = {frame_bytes[7], frame_bytes[6]};
                yaw_prod = pkt.yaw_raw;
                yaw_prod = (yaw_prod * 180) >>> 8;
                pkt.yaw_deg_q7 = yaw_prod[15:0];
                good_packets++;
            end else begin
                bad_sum_packets++;
            end
            expected_packets.push_back(pkt);
            produced = 1'b1;
            clear_frame();
        end
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    initial clear_frame();

    // Check output transactions, then predict from input transactions
    always @(posedge clk) begin : scoreboard
        result_t got, want;
        int      delta;
        bit      produced;
        if (rst_n) begin
            delta = 0;
            if (m_axis_tvalid && m_axis_tready) begin
                got.packet_ok  = m_axis_tdata[0];
                got.roll_raw   = m_axis_tdata[16:1];
                got.pitch_raw  = m_axis_tdata[32:17];
                got.yaw_raw    = m_axis_tdata[48:33];
                got.yaw_deg_q7 = m_axis_tdata[64:49];
                packets_seen <= packets_seen + 1;
                if (expected_packets.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = expected_packets.pop_front();
                    delta--;
                    check_field("packet_ok", 16'(want.packet_ok), 16'(got.packet_ok));
                    check_field("roll_raw", want.roll_raw, got.roll_raw);
                    check_field("pitch_raw", want.pitch_raw, got.pitch_raw);
                    check_field("yaw_raw", want.yaw_raw, got.yaw_raw);
                    check_field("yaw_deg_q7", want.yaw_deg_q7, got.yaw_deg_q7);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata, produced);
                if (produced)
                    delta++;
                bytes_in <= bytes_in + 1;
            end
            outstanding <= outstanding + delta;
        end
    end

    // Byte driver: offer the next byte, idle at random, hold at pause entries
    always @(posedge clk or negedge rst_n) begin : byte_driver
        logic       next_valid;
        logic [7:0] next_data;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            next_valid = 1'b0;
            next_data  = s_axis_tdata;
            if (byte_stream.size() > 0) begin
                if (byte_stream[0].pause) begin
                    if (!s_axis_tvalid && outstanding == 0)
                        void'(byte_stream.pop_front());
                end else if (calm || $urandom_range(0, 99) >= 7) begin
                    next_valid = 1'b1;
                    next_data  = byte_stream.pop_front().value;
                end
            end
            s_axis_tvalid <= next_valid;
            s_axis_tdata  <= next_data;
        end
    end

    // Result receiver: random stalls plus two long hold-offs
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!first_hold_done && bytes_in >= 150) begin
            first_hold_done <= 1'b1;
            stall_left      <= HOLD_CYCLES;
            m_axis_tready   <= 1'b0;
        end else if (!second_hold_done && bytes_in >= 900) begin
            second_hold_done <= 1'b1;
            stall_left       <= HOLD_CYCLES;
            m_axis_tready    <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);
        end
    end

    // Abort when neither side moves a transaction for too long
    always @(posedge clk) begin
        if (rst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end else begin
            idle_cycles <= 0;
        end
    end

    task automatic push_byte(input logic [7:0] value);
        stream_entry_t entry;
        entry.pause = 1'b0;
        entry.value = value;
        byte_stream.push_back(entry);
    endtask

    task automatic push_pause();
        stream_entry_t entry;
        entry.pause = 1'b1;
        entry.value = 8'h00;
        byte_stream.push_back(entry);
    endtask

    // Queue one framed packet; a bad checksum is offset by a nonzero amount
    task automatic push_packet(input logic [15:0] roll, input logic [15:0] pitch,
                               input logic [15:0] yaw, input logic [15:0] spare,
                               input bit good_sum);
        logic [7:0] body [0:9];
        logic [7:0] sum;
        body = '{HDR0, HDR1, roll[7:0], roll[15:8], pitch[7:0], pitch[15:8],
                 yaw[7:0], yaw[15:8], spare[7:0], spare[15:8]};
        sum = '0;
        foreach (body[i]) begin
            sum = sum + body[i];
            push_byte(body[i]);
        end
        if (!good_sum)
            sum = sum + 8'($urandom_range(1, 255));
        push_byte(sum);
    endtask

    initial begin
        int         packet_bytes;
        int         pick;
        logic [7:0] junk;
        bit         mid_pause_done;

        // Directed: bad headers, extreme angles, checksum failure
        push_byte(HDR0);
        push_byte(HDR0);
        push_byte(8'hAA);
        push_byte(HDR1);
        push_packet(16'h7FFF, 16'hFFFF, 16'h8000, 16'h00FF, 1'b1);
        push_packet(16'h8000, 16'h0000, 16'h7FFF, 16'hFF00, 1'b0);
        push_pause();

        // Random: mostly framed packets, some broken headers and noise pairs
        packet_bytes   = 0;
        mid_pause_done = 1'b0;
        while (packet_bytes < PACKET_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                push_packet(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            $urandom_range(0, 7) != 0);
                packet_bytes += PKT_LEN;
            end else if (pick < 88) begin
                if ($urandom_range(0, 1)) begin
                    do junk = 8'($urandom); while (junk == HDR1);
                    push_byte(HDR0);
                    push_byte(junk);
                end else begin
                    do junk = 8'($urandom); while (junk == HDR0);
                    push_byte(junk);
                    push_byte(HDR1);
                end
            end else begin
                repeat (2 * $urandom_range(1, 2))
                    push_byte(8'($urandom));
            end
            if (!mid_pause_done && packet_bytes >= PACKET_TARGET / 2) begin
                push_pause();
                mid_pause_done = 1'b1;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (byte_stream.size() == 0 && !s_axis_tvalid && outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Parsed %0d bytes into %0d packets: %0d good, %0d bad checksum, %0d pairs dropped",
                 bytes_in, packets_seen, good_packets, bad_sum_packets, dropped_pairs);
        $display("Output held off twice for %0d cycles; %0d mismatches", HOLD_CYCLES, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
